/* sv/ifr_pkg.sv */
// shared types, constants and helper functions of the integer factor image resizer
package ifr_pkg;

  localparam logic [12:0] MAX_DIM    = 13'd4096;
  localparam logic [3:0]  MAX_FACTOR = 4'd8;

  // reciprocal scaling for the floor divide by the factor
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 20;

  // register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_FACTOR = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // resize modes
  localparam logic MODE_UP   = 1'b0;
  localparam logic MODE_DOWN = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  k;
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] ow;
    logic [18:0] kow;
    logic [12:0] w2;
    logic [12:0] h2;
  } cfg_t;

  typedef struct packed {
    logic [11:0] in_col;
    logic [11:0] in_row;
    logic [2:0]  col_phase;
    logic [2:0]  row_phase;
    logic [14:0] out_col;
    logic [14:0] out_row;
  } pos_t;

  typedef struct packed {
    logic        emit;
    logic        single;
    logic [29:0] idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } job_t;

  function automatic logic [3:0] clamp_factor(input logic [3:0] f);
    logic [3:0] r;
    r = f;
    if (f == 4'd0) r = 4'd1;
    else if (f > MAX_FACTOR) r = MAX_FACTOR;
    return r;
  endfunction

  function automatic logic [12:0] clamp_dim(input logic [12:0] d);
    logic [12:0] r;
    r = d;
    if (d == 13'd0) r = 13'd1;
    else if (d > MAX_DIM) r = MAX_DIM;
    return r;
  endfunction

  // ceil(2^RECIP_SHIFT / k), exact floor quotient for dims up to MAX_DIM
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] k);
    logic [RECIP_W-1:0] r;
    unique case (k)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd5:    r = 20'd104858;
      4'd6:    r = 20'd87382;
      4'd7:    r = 20'd74899;
      default: r = 20'd65536;
    endcase
    return r;
  endfunction

endpackage

/* sv/ifr_cfg.sv */
// configuration registers and derived frame geometry
module ifr_cfg import ifr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output cfg_t        cfg,
  output logic        hold
);

  logic        mode;
  logic [3:0]  scale_factor;
  logic [12:0] in_width;
  logic [12:0] in_height;

  logic [3:0]  k_eff;
  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic [7:0]  k_sq;
  logic [32:0] w_quot;
  logic [32:0] h_quot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_UP;
      scale_factor <= 4'd2;
      in_width     <= 13'd640;
      in_height    <= 13'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   mode         <= cfg_data[0];
        REG_FACTOR: scale_factor <= cfg_data[3:0];
        REG_WIDTH:  in_width     <= cfg_data;
        REG_HEIGHT: in_height    <= cfg_data;
      endcase
    end
  end

  // derived values are registered, so input is held off after a write
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b1;
    end else begin
      hold <= cfg_valid;
    end
  end

  always_comb begin
    k_eff  = clamp_factor(scale_factor);
    w_eff  = clamp_dim(in_width);
    h_eff  = clamp_dim(in_height);
    k_sq   = 8'(k_eff) * 8'(k_eff);
    w_quot = 33'(w_eff) * 33'(recip(k_eff));
    h_quot = 33'(h_eff) * 33'(recip(k_eff));
  end

  always_ff @(posedge clk) begin
    cfg.mode <= mode;
    cfg.k    <= k_eff;
    cfg.w    <= w_eff;
    cfg.h    <= h_eff;
    cfg.ow   <= 16'(w_eff) * 16'(k_eff);
    cfg.kow  <= 19'(w_eff) * 19'(k_sq);
    cfg.w2   <= w_quot[RECIP_SHIFT+12:RECIP_SHIFT];
    cfg.h2   <= h_quot[RECIP_SHIFT+12:RECIP_SHIFT];
  end

endmodule

/* sv/ifr_pos.sv */
// raster position tracker of the input frame
module ifr_pos import ifr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  cfg_t cfg,
  output pos_t pos
);

  pos_t pos_next;

  always_comb begin
    pos_next = pos;
    if ((13'(pos.in_col) + 13'd1) >= cfg.w) begin
      pos_next.in_col    = '0;
      pos_next.col_phase = '0;
      pos_next.out_col   = '0;
      if ((13'(pos.in_row) + 13'd1) >= cfg.h) begin
        pos_next.in_row    = '0;
        pos_next.row_phase = '0;
        pos_next.out_row   = '0;
      end else begin
        pos_next.in_row = pos.in_row + 12'd1;
        if ((4'(pos.row_phase) + 4'd1) >= cfg.k) begin
          pos_next.row_phase = '0;
          pos_next.out_row   = pos.out_row + 15'd1;
        end else begin
          pos_next.row_phase = pos.row_phase + 3'd1;
        end
      end
    end else begin
      pos_next.in_col = pos.in_col + 12'd1;
      if ((4'(pos.col_phase) + 4'd1) >= cfg.k) begin
        pos_next.col_phase = '0;
        pos_next.out_col   = pos.out_col + 15'd1;
      end else begin
        pos_next.col_phase = pos.col_phase + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (adv) begin
      pos <= pos_next;
    end
  end

endmodule

/* sv/ifr_in.sv */
// input register with output index computation
module ifr_in import ifr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic        consume,
  input  logic [23:0] pix,
  input  pos_t        pos,
  input  cfg_t        cfg,
  output logic        job_valid,
  output job_t        job
);

  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  pos_t        p;
  logic [31:0] up_base;
  logic [29:0] dn_idx;
  logic        keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (load) begin
      job_valid <= 1'b1;
    end else if (consume) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red   <= pix[7:0];
      green <= pix[15:8];
      blue  <= pix[23:16];
      p     <= pos;
    end
  end

  always_comb begin
    // top left corner of the replicated block
    up_base = 32'(p.in_row) * 32'(cfg.kow) + 32'(p.in_col) * 32'(cfg.k);
    dn_idx  = 30'(p.out_row) * 30'(cfg.w2) + 30'(p.out_col);
    keep    = (p.col_phase == 3'd0) && (p.row_phase == 3'd0) &&
              (13'(p.in_col) < cfg.w) && (13'(p.in_row) < cfg.h) &&
              (p.out_col < 15'(cfg.w2)) && (p.out_row < 15'(cfg.h2));
    job.emit   = (cfg.mode == MODE_UP) || keep;
    job.single = (cfg.mode == MODE_DOWN) || (cfg.k == 4'd1);
    job.idx    = (cfg.mode == MODE_UP) ? up_base[29:0] : dn_idx;
    job.red    = red;
    job.green  = green;
    job.blue   = blue;
  end

endmodule

/* sv/ifr_emit.sv */
// block sequencer and result register
module ifr_emit import ifr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  input  cfg_t        cfg,
  output logic        consume,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,
  output logic        m_tlast
);

  logic [29:0] idx;
  logic [29:0] row_start;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last;
  logic [2:0]  i;
  logic [2:0]  j;

  logic        out_free;
  logic        more;
  logic        load;
  logic        step;
  logic        j_end;
  logic [2:0]  i_next;
  logic [2:0]  j_next;
  logic [29:0] row_next;
  logic        last_next;

  always_comb begin
    out_free  = !m_tvalid || m_tready;
    more      = m_tvalid && !last;
    consume   = job_valid && (!job.emit || (out_free && !more));
    load      = consume && job.emit;
    step      = out_free && more;
    j_end     = (4'(j) + 4'd1) == cfg.k;
    i_next    = j_end ? i + 3'd1 : i;
    j_next    = j_end ? 3'd0 : j + 3'd1;
    row_next  = row_start + 30'(cfg.ow);
    last_next = ((4'(i_next) + 4'd1) == cfg.k) && ((4'(j_next) + 4'd1) == cfg.k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (out_free && !more) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx       <= job.idx;
      row_start <= job.idx;
      red       <= job.red;
      green     <= job.green;
      blue      <= job.blue;
      last      <= job.single;
      i         <= 3'd0;
      j         <= 3'd0;
    end else if (step) begin
      i    <= i_next;
      j    <= j_next;
      last <= last_next;
      if (j_end) begin
        row_start <= row_next;
        idx       <= row_next;
      end else begin
        idx <= idx + 30'd1;
      end
    end
  end

  assign m_tdata = {2'b00, blue, green, red, idx};
  assign m_tlast = last;

endmodule

/* sv/integer_factor_image_resizer.sv */
// top level of the nearest neighbor integer factor image resizer
// a pixel is taken into the input register; its result words leave from the result register
// throughput: upscale gives one result word per cycle unless m_tready stalls, k*k words
//   per pixel from the block sequencer; downscale takes one pixel per cycle when not stalled
// a config write holds the input off while the derived geometry settles
// reset (rst, synchronous) restores default registers and returns the position to the origin
module integer_factor_image_resizer import ifr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // pixel input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // pixel_index, red_out, green_out, blue_out, zero pad
  output logic        m_tlast,   // run_last: final word of this pixel's results
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  cfg_t cfg;
  pos_t pos;
  job_t job;
  logic hold;
  logic job_valid;
  logic consume;
  logic load;

  // registers plus clamped factor, dims, output width and quotients
  ifr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .hold      (hold)
  );

  // the input register frees up when it is empty or its pixel moves on this cycle,
  // so a new pixel can come in while the last result word still waits
  assign s_tready = !hold && (!job_valid || consume);
  assign load     = s_tvalid && s_tready;

  // row, column, phase and output position of the next pixel
  ifr_pos u_pos (
    .clk (clk),
    .rst (rst),
    .adv (load),
    .cfg (cfg),
    .pos (pos)
  );

  // pixel with its position snapshot; computes the first output index and the
  // decimation keep decision
  ifr_in u_in (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .consume   (consume),
    .pix       (s_tdata),
    .pos       (pos),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job)
  );

  // walks the k-by-k block a word per cycle unless stalled; dropped pixels emit no word
  ifr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .cfg       (cfg),
    .consume   (consume),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

/* bench/tb_top.sv */
// self-checking bench for the integer factor image resizer: directed and random pixel streams
`timescale 1ns / 1ps

module tb_top;
  import ifr_pkg::*;

  // one result word as the block should present it
  typedef struct packed {
    logic [29:0] idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } out_word_t;

  // tracks the frame position and the registers, and holds the words still owed
  class resize_scoreboard;
    logic        mode;
    logic [3:0]  factor;
    logic [12:0] width;
    logic [12:0] height;
    logic [11:0] col_pos;
    logic [11:0] row_pos;
    logic [2:0]  col_ph;
    logic [2:0]  row_ph;
    logic [14:0] ocol;
    logic [14:0] orow;
    out_word_t   pending_words[$];
    int          errors;

    function new();
      mode    = MODE_UP;
      factor  = 4'd2;
      width   = 13'd640;
      height  = 13'd480;
      col_pos = '0;
      row_pos = '0;
      col_ph  = '0;
      row_ph  = '0;
      ocol    = '0;
      orow    = '0;
      errors  = 0;
    endfunction

    function int unsigned fit_dim(input logic [12:0] d);
      if (d == 13'd0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return d;
    endfunction

    function void note_reg(input logic [1:0] idx, input logic [12:0] val);
      case (idx)
        REG_MODE:   mode   = val[0];
        REG_FACTOR: factor = val[3:0];
        REG_WIDTH:  width  = val;
        REG_HEIGHT: height = val;
        default: ;
      endcase
    endfunction

    function void note_pixel(input logic [23:0] d);
      int unsigned     k, w, h, w2, h2, i, j;
      longint unsigned ow, r_o, c_o;
      out_word_t       wd;
      k = factor;
      if (k == 0) k = 1;
      else if (k > MAX_FACTOR) k = MAX_FACTOR;
      w = fit_dim(width);
      h = fit_dim(height);
      wd.red   = d[7:0];
      wd.green = d[15:8];
      wd.blue  = d[23:16];
      if (mode == MODE_UP) begin
        ow = longint'(w) * k;
        for (i = 0; i < k; i++) begin
          for (j = 0; j < k; j++) begin
            r_o = row_pos;
            r_o = r_o * k + i;
            c_o = col_pos;
            c_o = c_o * k + j;
            wd.idx  = 30'(r_o * ow + c_o);
            wd.last = (i + 1 == k) && (j + 1 == k);
            pending_words.push_back(wd);
          end
        end
      end else begin
        w2 = w / k;
        h2 = h / k;
        if (col_ph == 0 && row_ph == 0 && col_pos < w && row_pos < h &&
            ocol < w2 && orow < h2) begin
          r_o = orow;
          wd.idx  = 30'(r_o * w2 + ocol);
          wd.last = 1'b1;
          pending_words.push_back(wd);
        end
      end
      // raster advance; a phase at or past the factor restarts on the next carry
      if (int'(col_pos) + 1 >= w) begin
        col_pos = '0;
        col_ph  = '0;
        ocol    = '0;
        if (int'(row_pos) + 1 >= h) begin
          row_pos = '0;
          row_ph  = '0;
          orow    = '0;
        end else begin
          row_pos++;
          if (int'(row_ph) + 1 >= k) begin
            row_ph = '0;
            orow++;
          end else begin
            row_ph++;
          end
        end
      end else begin
        col_pos++;
        if (int'(col_ph) + 1 >= k) begin
          col_ph = '0;
          ocol++;
        end else begin
          col_ph++;
        end
      end
    endfunction

    function void report(input string what, input out_word_t want, input out_word_t got);
      errors++;
      if (errors <= 10)
        $display("%s: want idx=%0d rgb=%h/%h/%h last=%b, got idx=%0d rgb=%h/%h/%h last=%b",
                 what, want.idx, want.red, want.green, want.blue, want.last,
                 got.idx, got.red, got.green, got.blue, got.last);
    endfunction

    function void check_word(input logic [55:0] d, input logic l);
      out_word_t got, want;
      got.idx   = d[29:0];
      got.red   = d[37:30];
      got.green = d[45:38];
      got.blue  = d[53:46];
      got.last  = l;
      if (pending_words.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      want = pending_words.pop_front();
      if (got.idx !== want.idx || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.last !== want.last)
        report("word mismatch", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  // idling switches per phase, and the long receiver hold-off
  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;
  logic rx_hold = 1'b0;
  logic start_hold = 1'b0;

  resize_scoreboard sb = new();

  integer_factor_image_resizer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // handshakes are sampled at the falling edge, where every signal has settled;
  // the word then moves at the next rising edge

  // offer one pixel word, optionally after a random gap; valid stays high when no gap follows
  task automatic send_pixel(input logic [23:0] d);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sb.note_pixel(d);
  endtask

  // stop offering, wait for every owed word, then give the pipeline time to go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write all four registers back to back, valid held high across the writes
  task automatic set_config(input logic md, input logic [3:0] fac,
                            input logic [12:0] wid, input logic [12:0] hgt);
    logic [1:0]  ri;
    logic [12:0] rv;
    int          i;
    for (i = 0; i < 4; i++) begin
      case (i)
        0:       begin ri = REG_MODE;   rv = {12'd0, md};  end
        1:       begin ri = REG_FACTOR; rv = {9'd0, fac};  end
        2:       begin ri = REG_WIDTH;  rv = wid;          end
        default: begin ri = REG_HEIGHT; rv = hgt;          end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= ri;
      cfg_data  <= rv;
      do @(negedge clk); while (!cfg_ready);
      @(posedge clk);
      sb.note_reg(ri, rv);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly small frames so rows and frames wrap often, now and then an extreme
  function automatic logic [12:0] pick_dim(input int unsigned span);
    case ($urandom_range(0, 9))
      0:       return 13'd0;
      1:       return 13'($urandom_range(4096, 8191));
      2:       return MAX_DIM;
      default: return 13'($urandom_range(1, span));
    endcase
  endfunction

  // result side: per word a random stall if rx_idle, plus the long hold-off when asked
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (m_tvalid && m_tready) begin
        sb.check_word(m_tdata, m_tlast);
        stall = rx_idle ? $urandom_range(0, 17) : 0;
      end
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !rx_hold;
      end
    end
  end

  // long receiver stall so the block backs up and holds its input off
  initial begin : hold_off
    wait (start_hold);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (300) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin : stimulus
    logic        md;
    logic [3:0]  fac;
    logic [12:0] wid, hgt;
    int          n, rand_items, i;
    rand_items = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: upscale by two of a 640x480 frame, channel extremes
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    settle();

    // zero factor and zero sizes act as one; the position left over lies outside
    // the new frame and wraps after one pixel
    set_config(MODE_UP, 4'd0, 13'd0, 13'd0);
    send_pixel(24'h5AA55A);
    send_pixel(24'hA55AA5);
    settle();

    // oversized factor and sizes saturate: a full 8x8 block per pixel
    set_config(MODE_UP, 4'd15, 13'd8191, 13'd8191);
    send_pixel(24'hC3963C);
    settle();

    // downscale with a frame smaller than the factor gives nothing
    set_config(MODE_DOWN, 4'd8, 13'd7, 13'd5);
    repeat (3) send_pixel(24'($urandom()));
    settle();

    // smaller factor mid-frame: the stale phase restarts at zero on the next carry
    set_config(MODE_DOWN, 4'd3, 13'd12, 13'd6);
    repeat (6) send_pixel(24'($urandom()));
    settle();

    // factor one passes every pixel in the frame; the column left over is past the new width
    set_config(MODE_DOWN, 4'd1, 13'd3, 13'd2);
    repeat (5) send_pixel(24'($urandom()));
    settle();

    set_config(MODE_UP, 4'd2, 13'd3, 13'd3);
    send_pixel(24'h0F0F0F);
    send_pixel(24'hF0F0F0);
    send_pixel(24'h123456);
    settle();

    // first random phase: sender keeps pushing while the receiver holds off
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_config(MODE_UP, 4'd4, 13'd6, 13'd5);
    start_hold = 1'b1;
    for (i = 0; i < 30; i++) send_pixel(24'($urandom()));
    rand_items += 30;
    settle();

    // random geometry phases; the frame position carries over from phase to phase
    while (rand_items < 340) begin
      md = $urandom_range(0, 1) ? MODE_DOWN : MODE_UP;
      case ($urandom_range(0, 9))
        0:       fac = 4'd0;
        1:       fac = 4'($urandom_range(9, 15));
        2:       fac = 4'd8;
        default: fac = 4'($urandom_range(1, 5));
      endcase
      wid = pick_dim(12);
      hgt = pick_dim(8);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      set_config(md, fac, wid, hgt);
      // big factors in upscale are slow, keep those phases short
      n = (fac >= 4'd6) ? $urandom_range(4, 10) : $urandom_range(10, 36);
      for (i = 0; i < n; i++) send_pixel(24'($urandom()));
      rand_items += n;
      settle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* sim.f */
sv/ifr_pkg.sv
sv/ifr_cfg.sv
sv/ifr_pos.sv
sv/ifr_in.sv
sv/ifr_emit.sv
sv/integer_factor_image_resizer.sv
bench/tb_top.sv
